// ===== hdl/data_stack_alu_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DATA_STACK_ALU_DEFINES_SVH
`define DATA_STACK_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define DSA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DSA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dsa_pkg.sv =====
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int CELL_W          = 64;
  localparam int CMD_W           = 3;
  localparam int DEPTH_W         = 4;
  localparam int STACK_DEPTH_DEF = 10;
  localparam int DIV_STEP_W      = $clog2(CELL_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DUP  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SWAP = 3'd6;
  localparam logic [CMD_W-1:0] CMD_DROP = 3'd7;

  typedef logic [CELL_W-1:0] dsa_cell_t;

  // Divider request and response
  typedef struct packed {
    logic start;
    logic neg;
  } dsa_div_req_t;

  typedef struct packed {
    logic      done;
    dsa_cell_t quot;
  } dsa_div_rsp_t;

endpackage

// ===== hdl/dsa_div.sv =====
`timescale 1ns / 1ps
module dsa_div
  import dsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dsa_div_req_t req,
  input  dsa_cell_t    num_mag,
  input  dsa_cell_t    den_mag,
  output dsa_div_rsp_t rsp
);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIX  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;
  dsa_cell_t             rem_r, rem_nxt;
  dsa_cell_t             quo_r, quo_nxt;
  dsa_cell_t             den_r, den_nxt;
  logic                  neg_r, neg_nxt;
  logic                  done_r, done_nxt;
  dsa_cell_t             quot_r, quot_nxt;

  logic [CELL_W:0]       rem_sh;
  logic [CELL_W:0]       diff;
  logic                  take;

  // Shift in one numerator bit and trial-subtract the divisor
  assign rem_sh = {rem_r, quo_r[CELL_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign take   = ~diff[CELL_W];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    quot_nxt  = quot_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          rem_nxt   = '0;
          quo_nxt   = num_mag;
          den_nxt   = den_mag;
          neg_nxt   = req.neg;
          step_nxt  = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt  = take ? diff[CELL_W-1:0] : rem_sh[CELL_W-1:0];
        quo_nxt  = {quo_r[CELL_W-2:0], take};
        step_nxt = step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(CELL_W - 1)) begin
          state_nxt = D_FIX;
        end
      end
      D_FIX: begin
        // Apply the quotient sign
        quot_nxt  = neg_r ? (CELL_W'(0) - quo_r) : quo_r;
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== hdl/data_stack_alu.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                   Transfer
// command   start, busy, in_command, in_literal     start high while busy low
// result    out_strobe, out_value, out_depth,       one cycle with out_strobe high
//           out_overflow, out_underflow,
//           out_divide_by_zero
//
// Push, add, sub and drop finish in the execute state; dup and swap go on to a
// second write on the single memory write port, skipped for dup on a full stack
// or swap short of two cells; mul runs three 32x32 partial products through one
// multiplier; div takes one quotient bit per cycle, a zero divisor skips it.
// The result strobe comes in the same cycle as busy falls. Reset is synchronous and
// clears the cell count, not the cell memory; the receiver cannot stall.
module data_stack_alu
  import dsa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [CELL_W-1:0] in_literal,
  output logic                     out_strobe,
  output logic signed [CELL_W-1:0] out_value,
  output logic [DEPTH_W-1:0]       out_depth,
  output logic                     out_overflow,
  output logic                     out_underflow,
  output logic                     out_divide_by_zero
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int HW = CELL_W / 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;

  // Cell memory, two read ports and one write port
  dsa_cell_t mem [STACK_DEPTH];
  dsa_cell_t rd_top_r, rd_sec_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  dsa_cell_t     mem_wd;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  dsa_cell_t        lit_r, lit_nxt;
  dsa_cell_t        opa_r, opa_nxt;
  dsa_cell_t        opb_r, opb_nxt;
  logic [AW-1:0]    wadr_r, wadr_nxt;
  dsa_cell_t        wdat_r, wdat_nxt;
  logic [1:0]       mstep_r, mstep_nxt;
  dsa_cell_t        acc_r, acc_nxt;
  dsa_cell_t        prod_r, prod_nxt;
  logic             strobe_r, strobe_nxt;
  dsa_cell_t        value_r, value_nxt;
  logic             ovf_r, ovf_nxt;
  logic             unf_r, unf_nxt;
  logic             dz_r, dz_nxt;

  logic [CW-1:0]    cnt_m1, cnt_m2, base, pop1, pop1_p1;
  logic [CW+3:0]    cnt_ext;
  logic             has1, has2, full;
  dsa_cell_t        opnd_a, opnd_b, sum, dif, a_mag, b_mag;
  logic [HW-1:0]    mul_x, mul_y;

  dsa_div_req_t     div_req;
  dsa_div_rsp_t     div_rsp;

  // Stack pointer arithmetic
  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign has1    = (cnt_r != '0);
  assign has2    = (cnt_r >= CW'(2));
  assign full    = (cnt_r == CW'(STACK_DEPTH));
  assign base    = has2 ? cnt_m2 : '0;
  assign pop1    = has1 ? cnt_m1 : '0;
  assign pop1_p1 = pop1 + CW'(1);

  // Operands with missing cells read as zero
  assign opnd_a = has1 ? rd_top_r : '0;
  assign opnd_b = has2 ? rd_sec_r : '0;
  assign sum    = opnd_b + opnd_a;
  assign dif    = opnd_b - opnd_a;
  assign a_mag  = opnd_a[CELL_W-1] ? (CELL_W'(0) - opnd_a) : opnd_a;
  assign b_mag  = opnd_b[CELL_W-1] ? (CELL_W'(0) - opnd_b) : opnd_b;

  // Select the partial product for this step
  always_comb begin
    case (mstep_r)
      2'd0: begin
        mul_x = opa_r[HW-1:0];
        mul_y = opb_r[HW-1:0];
      end
      2'd1: begin
        mul_x = opa_r[HW-1:0];
        mul_y = opb_r[CELL_W-1:HW];
      end
      2'd2: begin
        mul_x = opa_r[CELL_W-1:HW];
        mul_y = opb_r[HW-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign prod_nxt = {{HW{1'b0}}, mul_x} * {{HW{1'b0}}, mul_y};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    lit_nxt    = lit_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    wadr_nxt   = wadr_r;
    wdat_nxt   = wdat_r;
    mstep_nxt  = mstep_r;
    acc_nxt    = acc_r;
    strobe_nxt = 1'b0;
    value_nxt  = value_r;
    ovf_nxt    = ovf_r;
    unf_nxt    = unf_r;
    dz_nxt     = dz_r;
    mem_we     = 1'b0;
    mem_wa     = wadr_r;
    mem_wd     = wdat_r;
    div_req    = '0;
    case (state_r)
      S_IDLE: begin
        // Capture the command on transfer
        if (start) begin
          cmd_nxt   = in_command;
          lit_nxt   = in_literal;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ovf_nxt    = 1'b0;
        unf_nxt    = 1'b0;
        dz_nxt     = 1'b0;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        case (cmd_r)
          CMD_PUSH: begin
            if (full) begin
              ovf_nxt   = 1'b1;
              value_nxt = opnd_a;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = cnt_r[AW-1:0];
              mem_wd    = lit_r;
              cnt_nxt   = cnt_r + CW'(1);
              value_nxt = lit_r;
            end
          end
          CMD_ADD: begin
            unf_nxt   = ~has2;
            mem_we    = 1'b1;
            mem_wa    = base[AW-1:0];
            mem_wd    = sum;
            cnt_nxt   = base + CW'(1);
            value_nxt = sum;
          end
          CMD_SUB: begin
            unf_nxt   = ~has2;
            mem_we    = 1'b1;
            mem_wa    = base[AW-1:0];
            mem_wd    = dif;
            cnt_nxt   = base + CW'(1);
            value_nxt = dif;
          end
          CMD_MUL: begin
            // Hand off to the partial-product sequence
            unf_nxt    = ~has2;
            opa_nxt    = opnd_a;
            opb_nxt    = opnd_b;
            wadr_nxt   = base[AW-1:0];
            cnt_nxt    = base + CW'(1);
            mstep_nxt  = 2'd0;
            strobe_nxt = 1'b0;
            state_nxt  = S_MUL;
          end
          CMD_DIV: begin
            unf_nxt = ~has2;
            cnt_nxt = base + CW'(1);
            if (opnd_a == '0) begin
              dz_nxt    = 1'b1;
              mem_we    = 1'b1;
              mem_wa    = base[AW-1:0];
              mem_wd    = '0;
              value_nxt = '0;
            end else begin
              div_req.start = 1'b1;
              div_req.neg   = opnd_a[CELL_W-1] ^ opnd_b[CELL_W-1];
              wadr_nxt      = base[AW-1:0];
              strobe_nxt    = 1'b0;
              state_nxt     = S_DIV;
            end
          end
          CMD_DUP: begin
            unf_nxt   = ~has1;
            mem_we    = 1'b1;
            mem_wa    = pop1[AW-1:0];
            mem_wd    = opnd_a;
            value_nxt = opnd_a;
            if (pop1_p1 < CW'(STACK_DEPTH)) begin
              wadr_nxt   = pop1_p1[AW-1:0];
              wdat_nxt   = opnd_a;
              cnt_nxt    = pop1 + CW'(2);
              strobe_nxt = 1'b0;
              state_nxt  = S_WR2;
            end else begin
              ovf_nxt = 1'b1;
              cnt_nxt = pop1_p1;
            end
          end
          CMD_SWAP: begin
            if (!has2) begin
              unf_nxt   = 1'b1;
              value_nxt = opnd_a;
            end else begin
              mem_we     = 1'b1;
              mem_wa     = cnt_m1[AW-1:0];
              mem_wd     = opnd_b;
              wadr_nxt   = cnt_m2[AW-1:0];
              wdat_nxt   = opnd_a;
              value_nxt  = opnd_b;
              strobe_nxt = 1'b0;
              state_nxt  = S_WR2;
            end
          end
          default: begin
            // Drop and output the top cell
            value_nxt = opnd_a;
            unf_nxt   = ~has1;
            cnt_nxt   = pop1;
          end
        endcase
      end
      S_MUL: begin
        // Accumulate the registered partial products
        mstep_nxt = mstep_r + 2'd1;
        case (mstep_r)
          2'd0:    acc_nxt = acc_r;
          2'd1:    acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[HW-1:0], {HW{1'b0}}};
        endcase
        if (mstep_r == 2'd3) begin
          mem_we     = 1'b1;
          mem_wd     = acc_nxt;
          value_nxt  = acc_nxt;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we     = 1'b1;
          mem_wd     = div_rsp.quot;
          value_nxt  = div_rsp.quot;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WR2: begin
        mem_we     = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  dsa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .num_mag (b_mag),
    .den_mag (a_mag),
    .rsp     (div_rsp)
  );

  // Write and read the cell memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_top_r <= mem[cnt_m1[AW-1:0]];
    rd_sec_r <= mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    lit_r   <= lit_nxt;
    opa_r   <= opa_nxt;
    opb_r   <= opb_nxt;
    wadr_r  <= wadr_nxt;
    wdat_r  <= wdat_nxt;
    mstep_r <= mstep_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    value_r <= value_nxt;
    ovf_r   <= ovf_nxt;
    unf_r   <= unf_nxt;
    dz_r    <= dz_nxt;
  end

  assign cnt_ext            = {4'b0, cnt_r};
  assign busy               = (state_r != S_IDLE);
  assign out_strobe         = strobe_r;
  assign out_value          = value_r;
  assign out_depth          = cnt_ext[DEPTH_W-1:0];
  assign out_overflow       = ovf_r;
  assign out_underflow      = unf_r;
  assign out_divide_by_zero = dz_r;

endmodule

// ===== hdl/dsa_chk.sv =====
`timescale 1ns / 1ps
`include "data_stack_alu_defines.svh"
module dsa_chk
  import dsa_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_strobe,
  input logic signed [CELL_W-1:0] out_value,
  input logic [DEPTH_W-1:0]       out_depth,
  input logic                     out_overflow,
  input logic                     out_divide_by_zero
);

  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

  // A transfer starts work
  `DSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy low after transfer")
  // A result only appears once the command is finished
  `DSA_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result while busy")
  // One result per command, never back to back
  `DSA_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "strobe held")
  // An overflow, from push or dup, leaves a full stack
  `DSA_ASSERT_SAME(a_ovf_full, clk, rst_n, out_strobe && out_overflow,
    out_depth == FULL_DEPTH, "overflow without full stack")
  // A zero divisor pushes zero
  `DSA_ASSERT_SAME(a_dz_zero, clk, rst_n, out_strobe && out_divide_by_zero,
    out_value == '0, "divide by zero gave nonzero")

endmodule

bind data_stack_alu dsa_chk #(.STACK_DEPTH(STACK_DEPTH)) u_dsa_chk (.*);

// ===== tb/sv/data_stack_alu_tb.sv =====
`timescale 1ns / 1ps
module data_stack_alu_tb;
  import dsa_pkg::*;

  localparam int        DEPTH        = STACK_DEPTH_DEF;
  localparam int        RANDOM_ITEMS = 600;
  localparam int        DRAIN_CYCLES = 100;
  localparam int        CYCLE_LIMIT  = 400000;
  localparam int        PRINT_LIMIT  = 100;
  localparam dsa_cell_t MOST_NEG     = 64'h8000_0000_0000_0000;
  localparam dsa_cell_t MOST_POS     = 64'h7fff_ffff_ffff_ffff;
  localparam dsa_cell_t ALL_ONES     = 64'hffff_ffff_ffff_ffff;

  typedef struct {
    dsa_cell_t          value;
    logic [DEPTH_W-1:0] depth;
    logic               overflow;
    logic               underflow;
    logic               div_zero;
  } outcome_t;

  typedef struct {
    logic [CMD_W-1:0] command;
    dsa_cell_t        literal;
    int               reps;
    bit               typed;
    outcome_t         outcome;
  } script_row_t;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic [CMD_W-1:0]         in_command = CMD_PUSH;
  logic signed [CELL_W-1:0] in_literal = '0;
  logic                     busy;
  logic                     out_strobe;
  logic signed [CELL_W-1:0] out_value;
  logic [DEPTH_W-1:0]       out_depth;
  logic                     out_overflow;
  logic                     out_underflow;
  logic                     out_divide_by_zero;

  // Outcome typed into the script, travels with the command it belongs to
  bit       row_typed   = 1'b0;
  outcome_t row_outcome = '{default: '0};

  // Stack mirror
  dsa_cell_t   stack_cells [DEPTH];
  int unsigned cell_count = 0;
  bit          push_dropped;
  bit          pop_missed;

  outcome_t    command_outcomes[$];
  outcome_t    oldest;
  outcome_t    mirrored;
  script_row_t script[$];
  int          error_count = 0;
  int          cycle_count = 0;

  always #6 clk = ~clk;

  data_stack_alu i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_literal        (in_literal),
    .out_strobe        (out_strobe),
    .out_value         (out_value),
    .out_depth         (out_depth),
    .out_overflow      (out_overflow),
    .out_underflow     (out_underflow),
    .out_divide_by_zero(out_divide_by_zero)
  );

  function automatic void push_cell_value(dsa_cell_t v);
    if (cell_count >= DEPTH) begin
      push_dropped = 1'b1;
    end else begin
      stack_cells[cell_count] = v;
      cell_count++;
    end
  endfunction

  // Pop the top cell; an empty stack yields zero
  function automatic dsa_cell_t pop_cell_value();
    dsa_cell_t v;
    v = '0;
    if (cell_count == 0) begin
      pop_missed = 1'b1;
    end else begin
      cell_count--;
      v = stack_cells[cell_count];
    end
    return v;
  endfunction

  // Signed division truncated toward zero, built on unsigned magnitudes
  function automatic dsa_cell_t truncated_quotient(dsa_cell_t num, dsa_cell_t den);
    dsa_cell_t mag_num;
    dsa_cell_t mag_den;
    dsa_cell_t quot;
    mag_num = num[CELL_W-1] ? 64'd0 - num : num;
    mag_den = den[CELL_W-1] ? 64'd0 - den : den;
    quot    = mag_num / mag_den;
    if (num[CELL_W-1] ^ den[CELL_W-1]) quot = 64'd0 - quot;
    return quot;
  endfunction

  // Apply one command to the mirror and return the outcome it shows
  function automatic outcome_t execute_command(logic [CMD_W-1:0] cmd, dsa_cell_t lit);
    outcome_t  o;
    dsa_cell_t top;
    dsa_cell_t second;
    bit        div_zero;
    o            = '{default: '0};
    push_dropped = 1'b0;
    pop_missed   = 1'b0;
    div_zero     = 1'b0;
    case (cmd)
      CMD_PUSH: push_cell_value(lit);
      CMD_ADD: begin
        top    = pop_cell_value();
        second = pop_cell_value();
        push_cell_value(second + top);
      end
      CMD_SUB: begin
        top    = pop_cell_value();
        second = pop_cell_value();
        push_cell_value(second - top);
      end
      CMD_MUL: begin
        top    = pop_cell_value();
        second = pop_cell_value();
        push_cell_value(second * top);
      end
      CMD_DIV: begin
        top    = pop_cell_value();
        second = pop_cell_value();
        if (top == '0) begin
          div_zero = 1'b1;
          push_cell_value('0);
        end else begin
          push_cell_value(truncated_quotient(second, top));
        end
      end
      CMD_DUP: begin
        top = pop_cell_value();
        push_cell_value(top);
        push_cell_value(top);
      end
      CMD_SWAP: begin
        if (cell_count < 2) begin
          pop_missed = 1'b1;
        end else begin
          top                        = stack_cells[cell_count - 1];
          stack_cells[cell_count - 1] = stack_cells[cell_count - 2];
          stack_cells[cell_count - 2] = top;
        end
      end
      default: o.value = pop_cell_value();
    endcase
    if (cmd != CMD_DROP && cell_count > 0) o.value = stack_cells[cell_count - 1];
    o.depth     = DEPTH_W'(cell_count);
    o.overflow  = push_dropped;
    o.underflow = pop_missed;
    o.div_zero  = div_zero;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
    error_count++;
  endtask

  // Script row checked against the mirror
  task automatic script_step(logic [CMD_W-1:0] cmd, dsa_cell_t lit, int reps);
    script.push_back('{cmd, lit, reps, 1'b0, '{default: '0}});
  endtask

  // Script row with its outcome written out
  task automatic script_check(logic [CMD_W-1:0] cmd, dsa_cell_t lit, dsa_cell_t v,
                              logic [DEPTH_W-1:0] d, logic ovf, logic unf, logic dz);
    script.push_back('{cmd, lit, 1, 1'b1, '{v, d, ovf, unf, dz}});
  endtask

  // Offer one command and hold it until the transfer
  task automatic issue_command(logic [CMD_W-1:0] cmd, dsa_cell_t lit, bit typed,
                               outcome_t typed_outcome);
    start       <= 1'b1;
    in_command  <= cmd;
    in_literal  <= lit;
    row_typed   <= typed;
    row_outcome <= typed_outcome;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit idling);
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check each result, then mirror each command transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (command_outcomes.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          oldest = command_outcomes.pop_front();
          if (out_value !== oldest.value)
            report_mismatch($sformatf("value %h, want %h", out_value, oldest.value));
          if (out_depth !== oldest.depth)
            report_mismatch($sformatf("depth %0d, want %0d", out_depth, oldest.depth));
          if (out_overflow !== oldest.overflow)
            report_mismatch($sformatf("overflow %b, want %b", out_overflow,
                                      oldest.overflow));
          if (out_underflow !== oldest.underflow)
            report_mismatch($sformatf("underflow %b, want %b", out_underflow,
                                      oldest.underflow));
          if (out_divide_by_zero !== oldest.div_zero)
            report_mismatch($sformatf("divide_by_zero %b, want %b", out_divide_by_zero,
                                      oldest.div_zero));
        end
      end
      if (start && !busy) begin
        mirrored = execute_command(in_command, in_literal);
        command_outcomes.push_back(row_typed ? row_outcome : mirrored);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("data_stack_alu regression: fail");
      $finish;
    end
  end

  initial begin
    outcome_t         none;
    logic [CMD_W-1:0] cmd;
    dsa_cell_t        lit;
    int               push_pct;
    int               drop_pct;
    int               r;
    bit               idling;
    none     = '{default: '0};
    push_pct = 30;
    drop_pct = 10;
    idling   = 1'b1;

    // Empty stack: pops give zero with underflow
    script_check(CMD_DROP, ALL_ONES, '0, 4'd0, 1'b0, 1'b1, 1'b0);
    script_check(CMD_SWAP, ALL_ONES, '0, 4'd0, 1'b0, 1'b1, 1'b0);
    script_check(CMD_DUP,  ALL_ONES, '0, 4'd2, 1'b0, 1'b1, 1'b0);
    script_step(CMD_DROP, ALL_ONES, 1);
    // Binary operation with one operand missing
    script_step(CMD_ADD, ALL_ONES, 1);
    // Most negative over minus one wraps
    script_check(CMD_PUSH, MOST_NEG, MOST_NEG, 4'd2, 1'b0, 1'b0, 1'b0);
    script_step(CMD_PUSH, ALL_ONES, 1);
    script_check(CMD_DIV, '0, MOST_NEG, 4'd2, 1'b0, 1'b0, 1'b0);
    // Zero divisor
    script_step(CMD_PUSH, '0, 1);
    script_check(CMD_DIV, ALL_ONES, '0, 4'd2, 1'b0, 1'b0, 1'b1);
    // Swap, subtract order, truncation toward zero, wrapping multiply
    script_step(CMD_PUSH, -64'sd7, 1);
    script_step(CMD_SWAP, '0, 1);
    script_step(CMD_SUB, ALL_ONES, 1);
    script_step(CMD_PUSH, 64'sd2, 1);
    script_step(CMD_DIV, '0, 1);
    script_step(CMD_PUSH, MOST_POS, 1);
    script_step(CMD_MUL, ALL_ONES, 1);
    // Fill the stack, then push and dup on a full stack
    script_step(CMD_DUP, '0, 8);
    script_step(CMD_PUSH, 64'sd1, 1);
    script_step(CMD_DUP, '0, 1);
    script_step(CMD_DROP, '0, 1);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the script
    foreach (script[i]) begin
      for (int k = 0; k < script[i].reps; k++) begin
        issue_command(script[i].command, script[i].literal, script[i].typed,
                      script[i].outcome);
        idle_for(pick_gap(1'b1));
      end
    end

    // Random commands in blocks that lean toward filling, draining or neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: begin push_pct = 30; drop_pct = 10; end
          1: begin push_pct = 60; drop_pct = 8;  end
          default: begin push_pct = 12; drop_pct = 35; end
        endcase
        idling = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) cmd = CMD_PUSH;
      else if (r < push_pct + drop_pct) cmd = CMD_DROP;
      else cmd = CMD_W'($urandom_range(CMD_SWAP, CMD_ADD));
      case ($urandom_range(0, 7))
        0: lit = '0;
        1: lit = ALL_ONES;
        2: lit = MOST_NEG;
        3: lit = MOST_POS;
        4: lit = dsa_cell_t'(longint'($urandom_range(0, 40)) - 64'sd20);
        default: lit = {$urandom, $urandom};
      endcase
      issue_command(cmd, lit, 1'b0, none);
      idle_for(pick_gap(idling));
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (command_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("data_stack_alu regression: pass");
    end else begin
      $display("data_stack_alu regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dsa_pkg.sv
hdl/dsa_div.sv
hdl/data_stack_alu.sv
hdl/dsa_chk.sv
tb/sv/data_stack_alu_tb.sv
